@@ rtl/eds_pkg.sv @@
package eds_pkg;

   localparam int FIELD_BITS = 15;
   localparam int COORD_BITS = 15;
   localparam int SQ_BITS    = 31;
   localparam int ROOT_BITS  = 16;
   localparam int PROD_BITS  = 2 * FIELD_BITS;
   localparam int TRIAL_BITS = 2 * ROOT_BITS + 1;

   localparam logic [FIELD_BITS-1:0] COORD_MASK =
      FIELD_BITS'((64'd1 << COORD_BITS) - 64'd1);

   typedef struct packed {
      logic [FIELD_BITS-1:0] first_x;
      logic [FIELD_BITS-1:0] first_y;
      logic [FIELD_BITS-1:0] second_x;
      logic [FIELD_BITS-1:0] second_y;
   } eds_req_type;

   typedef struct packed {
      logic [SQ_BITS-1:0]   squared_distance;
      logic [ROOT_BITS-1:0] rounded_down_distance;
   } eds_rsp_type;

   typedef struct packed {
      logic               valid;
      logic [SQ_BITS-1:0] squared_distance;
   } eds_sq_type;

endpackage

@@ rtl/eds_sqdist.sv @@
module eds_sqdist (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  eds_pkg::eds_req_type req_data,
   output eds_pkg::eds_sq_type  sq_out
);

   logic [eds_pkg::FIELD_BITS-1:0] ax, ay, bx, by;
   logic [eds_pkg::FIELD_BITS-1:0] dx_in, dy_in, dx_ff, dy_ff;
   logic [eds_pkg::PROD_BITS-1:0]  dxsq_in, dysq_in, dxsq_ff, dysq_ff;
   logic [eds_pkg::SQ_BITS-1:0]    sq_in, sq_ff;
   logic                           v1_ff, v2_ff, v3_ff;

   // stage 1: axis differences
   always_comb begin
      ax    = req_data.first_x & eds_pkg::COORD_MASK;
      ay    = req_data.first_y & eds_pkg::COORD_MASK;
      bx    = req_data.second_x & eds_pkg::COORD_MASK;
      by    = req_data.second_y & eds_pkg::COORD_MASK;
      dx_in = (bx < ax) ? (ax - bx) : (bx - ax);
      dy_in = (by < ay) ? (ay - by) : (by - ay);
   end

   // stage 2: squares
   assign dxsq_in = eds_pkg::PROD_BITS'(dx_ff) * eds_pkg::PROD_BITS'(dx_ff);
   assign dysq_in = eds_pkg::PROD_BITS'(dy_ff) * eds_pkg::PROD_BITS'(dy_ff);

   // stage 3: sum
   assign sq_in = eds_pkg::SQ_BITS'(dxsq_ff) + eds_pkg::SQ_BITS'(dysq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      dxsq_ff <= dxsq_in;
      dysq_ff <= dysq_in;
      sq_ff   <= sq_in;
   end

   assign sq_out.valid            = v3_ff;
   assign sq_out.squared_distance = sq_ff;

endmodule

@@ rtl/eds_isqrt.sv @@
module eds_isqrt (
   input  logic                clock,
   input  logic                reset,
   input  eds_pkg::eds_sq_type  sq_in,
   output logic                rsp_valid,
   output eds_pkg::eds_rsp_type rsp_data
);

   localparam int N = eds_pkg::ROOT_BITS;

   logic                           vld_ff  [0:N-1];
   logic [eds_pkg::SQ_BITS-1:0]    sq_ff   [0:N-1];
   logic [eds_pkg::SQ_BITS-1:0]    rem_ff  [0:N-1];
   logic [eds_pkg::ROOT_BITS-1:0]  root_ff [0:N-1];

   logic                           vld_src  [0:N-1];
   logic [eds_pkg::SQ_BITS-1:0]    sq_src   [0:N-1];
   logic [eds_pkg::SQ_BITS-1:0]    rem_src  [0:N-1];
   logic [eds_pkg::ROOT_BITS-1:0]  root_src [0:N-1];

   assign vld_src[0]  = sq_in.valid;
   assign sq_src[0]   = sq_in.squared_distance;
   assign rem_src[0]  = sq_in.squared_distance;
   assign root_src[0] = '0;

   genvar k;
   generate
      for (k = 0; k < N; k++) begin : g_round
         localparam int SHIFT = N - 1 - k;

         logic [eds_pkg::TRIAL_BITS-1:0] trial;
         logic [eds_pkg::TRIAL_BITS-1:0] rem_wide;
         logic                           take;
         logic [eds_pkg::SQ_BITS-1:0]    rem_in;
         logic [eds_pkg::ROOT_BITS-1:0]  root_in;

         if (k > 0) begin : g_link
            assign vld_src[k]  = vld_ff[k-1];
            assign sq_src[k]   = sq_ff[k-1];
            assign rem_src[k]  = rem_ff[k-1];
            assign root_src[k] = root_ff[k-1];
         end

         // trial = (2*root + bit) << shift
         assign trial = (eds_pkg::TRIAL_BITS'(root_src[k]) << (SHIFT + 1))
                      + (eds_pkg::TRIAL_BITS'(1) << (2 * SHIFT));
         assign rem_wide = eds_pkg::TRIAL_BITS'(rem_src[k]);
         assign take     = (rem_wide >= trial);
         assign rem_in   = take ? eds_pkg::SQ_BITS'(rem_wide - trial) : rem_src[k];
         assign root_in  = take ? (root_src[k] | (eds_pkg::ROOT_BITS'(1) << SHIFT))
                                : root_src[k];

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else begin
               vld_ff[k] <= vld_src[k];
            end
         end

         always_ff @(posedge clock) begin
            sq_ff[k]   <= sq_src[k];
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   endgenerate

   assign rsp_valid                      = vld_ff[N-1];
   assign rsp_data.squared_distance      = sq_ff[N-1];
   assign rsp_data.rounded_down_distance = root_ff[N-1];

endmodule

@@ rtl/euclidean_distance_isqrt_unit.sv @@
// the result strobe follows the start beat through the registered difference, square and sum
// stages, then through the root stages, which settle one root bit per stage
// throughput: one beat per cycle; busy is always low
// reset clears only the stage valid bits; no result strobes until new beats arrive
module euclidean_distance_isqrt_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  eds_pkg::eds_req_type req_data,
   output logic                rsp_strobe,
   output eds_pkg::eds_rsp_type rsp_data
);

   eds_pkg::eds_sq_type sq_link;
   logic                accept;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   eds_sqdist u_sqdist (
      .clock     (clock),
      .reset     (reset),
      .req_valid (accept),
      .req_data  (req_data),
      .sq_out    (sq_link)
   );

   eds_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .sq_in     (sq_link),
      .rsp_valid (rsp_strobe),
      .rsp_data  (rsp_data)
   );

endmodule
